// ===== hdl/bzct_pkg.sv =====
// Package for the BLDC zero-cross commutation tracker.
// Holds result codes, register indexes, reset values and the timing constants.
// No dependencies.
`default_nettype none

package bzct_pkg;

  // Register index and data widths of the configuration channel.
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_STARTUP_CONF   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STARTUP_PERIOD = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_CONF      = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_REJECT_BLANK   = 8'd3;

  // Register reset values.
  localparam logic [7:0]  RST_STARTUP_CONF   = 8'd2;
  localparam logic [15:0] RST_STARTUP_PERIOD = 16'd20000;
  localparam logic [7:0]  RST_SLOW_CONF      = 8'd20;
  localparam logic [15:0] RST_REJECT_BLANK   = 16'd20000;

  // Interval thresholds in timer ticks.
  localparam logic [31:0] ZC_MIN_TICKS  = 32'd300;
  localparam logic [31:0] FAST_TICKS    = 32'd6000;
  localparam logic [31:0] MEDIUM_TICKS  = 32'd8000;
  localparam logic [31:0] SLOW_TICKS    = 32'd10000;

  // Lower limits of the run confirmation count per speed band.
  localparam logic [7:0] FAST_MIN_CONF   = 8'd6;
  localparam logic [7:0] MEDIUM_MIN_CONF = 8'd8;
  localparam logic [7:0] SLOW_MIN_CONF   = 8'd10;

  // Request kinds.
  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_TIMEOUT = 1'b1;

  // Result codes.
  typedef enum logic [1:0] {
    OUT_CONFIRMING = 2'd0,
    OUT_REJECTED   = 2'd1,
    OUT_ACCEPTED   = 2'd2,
    OUT_TIMEOUT    = 2'd3
  } outcome_e;

endpackage

`default_nettype wire

// ===== hdl/bzct_in_if.sv =====
// Input request channel of the zero-cross tracker: one comparator sample or timeout.
// Depends on nothing.
`default_nettype none

interface bzct_in_if #(
  parameter int unsigned TIMER_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic                  comp_level;
  logic [TIMER_BITS-1:0] zc_count;

  modport source (output valid, output req_type, output comp_level, output zc_count,
                  input ready);
  modport sink   (input valid, input req_type, input comp_level, input zc_count,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/bzct_out_if.sv =====
// Result channel of the zero-cross tracker.
// Depends on bzct_pkg for the result code type.
`default_nettype none

interface bzct_out_if #(
  parameter int unsigned TIMER_BITS = 16
);
  logic                  valid;
  logic                  ready;
  bzct_pkg::outcome_e    outcome;
  logic [15:0]           blank_ticks;
  logic [TIMER_BITS-1:0] period_out;
  logic                  comm_load_valid;
  logic [TIMER_BITS-2:0] comm_load_value;
  logic [TIMER_BITS-4:0] blank_compare;
  logic                  starting_out;
  logic [7:0]            confirm_needed;

  modport source (output valid, output outcome, output blank_ticks, output period_out,
                  output comm_load_valid, output comm_load_value, output blank_compare,
                  output starting_out, output confirm_needed, input ready);
  modport sink   (input valid, input outcome, input blank_ticks, input period_out,
                  input comm_load_valid, input comm_load_value, input blank_compare,
                  input starting_out, input confirm_needed, output ready);
endinterface

`default_nettype wire

// ===== hdl/bzct_cfg_if.sv =====
// Configuration write channel of the zero-cross tracker.
// Depends on bzct_pkg for the index and data widths.
`default_nettype none

interface bzct_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bzct_pkg::CFG_INDEX_W-1:0]  index;
  logic [bzct_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bldc_zero_cross_commutation_tracker.sv =====
// BLDC sensorless zero-cross commutation tracker, top level.
// The result of an accepted request is registered in the output register.
// Throughput: one request per cycle; the single output register stalls intake only
// while a result waits and the sink is not ready. Configuration writes are never stalled.
// Reset: asynchronous, active low; registers and tracker state return to their
// defaults and the output register is emptied.
`default_nettype none

module bldc_zero_cross_commutation_tracker #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  bzct_cfg_if.sink    cfg_i,
  bzct_in_if.sink     in_i,
  bzct_out_if.source  out_o
);
  import bzct_pkg::*;

  localparam int unsigned TW = TIMER_BITS;

  // Configuration registers.
  logic [7:0]  startup_conf_q;
  logic [15:0] startup_period_q;
  logic [7:0]  slow_conf_q;
  logic [15:0] reject_blank_q;

  // Tracker state.
  logic          start_mode_q, start_mode_d;
  logic [7:0]    remaining_q, remaining_d;
  logic [7:0]    required_q, required_d;
  logic [7:0]    run_conf_q, run_conf_d;
  logic [TW-1:0] period_q, period_d;

  // Output register.
  logic          out_valid_q;
  outcome_e      outcome_q, outcome_d;
  logic [15:0]   blank_q, blank_d;
  logic [TW-1:0] period_out_q;
  logic          load_valid_q, load_valid_d;
  logic [TW-2:0] load_value_q, load_value_d;
  logic [TW-4:0] bcmp_q, bcmp_d;
  logic          starting_q;
  logic [7:0]    confirm_q;

  logic          in_fire;
  logic [TW-1:0] startup_period_t;
  logic [TW-1:0] half_p;
  logic [TW-1:0] quarter_p;
  logic [TW:0]   late_limit;
  logic [TW-1:0] filtered_p;
  logic [31:0]   cnt_w;
  logic          starting_now;
  logic [7:0]    run_next;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_conf_q   <= RST_STARTUP_CONF;
      startup_period_q <= RST_STARTUP_PERIOD;
      slow_conf_q      <= RST_SLOW_CONF;
      reject_blank_q   <= RST_REJECT_BLANK;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_STARTUP_CONF:   startup_conf_q   <= cfg_i.data[7:0];
        CFG_STARTUP_PERIOD: startup_period_q <= cfg_i.data[15:0];
        CFG_SLOW_CONF:      slow_conf_q      <= cfg_i.data[7:0];
        CFG_REJECT_BLANK:   reject_blank_q   <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // Period arithmetic on the current state.
  assign startup_period_t = TW'(startup_period_q);
  assign half_p           = period_q >> 1;
  assign quarter_p        = period_q >> 2;
  assign late_limit       = {1'b0, period_q} + {1'b0, half_p} + {1'b0, quarter_p};
  assign filtered_p       = half_p + quarter_p + (in_i.zc_count >> 2);
  assign cnt_w            = 32'(in_i.zc_count);
  assign starting_now     = start_mode_q || (cnt_w < ZC_MIN_TICKS);

  // Run confirmation adaptation by speed band.
  always_comb begin
    run_next = run_conf_q;
    if (cnt_w < FAST_TICKS) begin
      if (run_conf_q > FAST_MIN_CONF) run_next = run_conf_q - 8'd1;
    end else if (cnt_w < MEDIUM_TICKS) begin
      if (run_conf_q > MEDIUM_MIN_CONF) run_next = run_conf_q - 8'd1;
    end else if (cnt_w < SLOW_TICKS) begin
      if (run_conf_q > SLOW_MIN_CONF) run_next = run_conf_q - 8'd1;
    end else begin
      if (run_conf_q < slow_conf_q) run_next = run_conf_q + 8'd1;
    end
  end

  // Request evaluation: next state and result fields.
  always_comb begin
    start_mode_d = start_mode_q;
    remaining_d  = remaining_q;
    required_d   = required_q;
    run_conf_d   = run_conf_q;
    period_d     = period_q;
    outcome_d    = OUT_CONFIRMING;
    blank_d      = '0;
    load_valid_d = 1'b0;
    load_value_d = '0;
    bcmp_d       = '0;
    if (in_i.req_type == REQ_TIMEOUT) begin
      start_mode_d = 1'b1;
      outcome_d    = OUT_TIMEOUT;
    end else if (!in_i.comp_level) begin
      remaining_d = required_q;
      outcome_d   = OUT_REJECTED;
      blank_d     = reject_blank_q;
    end else if (remaining_q > 8'd1) begin
      remaining_d = remaining_q - 8'd1;
    end else begin
      outcome_d    = OUT_ACCEPTED;
      start_mode_d = starting_now;
      if (in_i.zc_count < half_p) begin
        // Too early: restart the period only while starting.
        if (starting_now) begin
          required_d = startup_conf_q;
          period_d   = startup_period_t;
        end
      end else if ({1'b0, in_i.zc_count} > late_limit) begin
        // Missed window: period and required count are kept.
      end else if (starting_now) begin
        start_mode_d = 1'b0;
      end else begin
        run_conf_d   = run_next;
        required_d   = run_next;
        period_d     = filtered_p;
        load_valid_d = 1'b1;
        load_value_d = filtered_p[TW-1:1];
      end
      remaining_d = required_d;
      bcmp_d      = period_d[TW-1:3];
    end
  end

  // Tracker state update on each accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_mode_q <= 1'b1;
      remaining_q  <= RST_STARTUP_CONF;
      required_q   <= RST_STARTUP_CONF;
      run_conf_q   <= RST_SLOW_CONF;
      period_q     <= TW'(RST_STARTUP_PERIOD);
    end else if (in_fire) begin
      start_mode_q <= start_mode_d;
      remaining_q  <= remaining_d;
      required_q   <= required_d;
      run_conf_q   <= run_conf_d;
      period_q     <= period_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      outcome_q    <= outcome_d;
      blank_q      <= blank_d;
      period_out_q <= period_d;
      load_valid_q <= load_valid_d;
      load_value_q <= load_value_d;
      bcmp_q       <= bcmp_d;
      starting_q   <= start_mode_d;
      confirm_q    <= required_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.outcome         = outcome_q;
  assign out_o.blank_ticks     = blank_q;
  assign out_o.period_out      = period_out_q;
  assign out_o.comm_load_valid = load_valid_q;
  assign out_o.comm_load_value = load_value_q;
  assign out_o.blank_compare   = bcmp_q;
  assign out_o.starting_out    = starting_q;
  assign out_o.confirm_needed  = confirm_q;

`ifndef SYNTH
  // A timeout request always reports start-up mode in its result.
  a_timeout_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.req_type == REQ_TIMEOUT) |=>
      (out_o.valid && out_o.outcome == OUT_TIMEOUT && out_o.starting_out))
    else $error("timeout request did not report start-up mode");

  // A commutation load only comes from closed-loop operation on an accepted crossing.
  a_load_closed_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.comm_load_valid) |->
      (!out_o.starting_out && out_o.outcome == OUT_ACCEPTED))
    else $error("commutation load outside closed-loop acceptance");

  // Blanking is only requested by a rejected sample.
  a_blank_on_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.outcome != OUT_REJECTED) |-> (out_o.blank_ticks == '0))
    else $error("blanking requested without a rejected sample");

  // After an accepted crossing the run count is reloaded from the required count.
  a_reload_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && outcome_d == OUT_ACCEPTED) |=> (remaining_q == required_q))
    else $error("run count not reloaded after an accepted crossing");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for the BLDC zero-cross commutation tracker: directed requests, register
// extremes, output back-pressure and random crossing traffic, checked against a local model.
// Depends on bzct_pkg, the three channel interfaces and the tracker top level.

module testbench;
  import bzct_pkg::*;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned RUN_LIMIT    = 400000;
  localparam int unsigned PHASE_ITEMS  = 220;

  // Indexes that name no register; writes to them must leave everything alone.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAST_INDEX  = 8'hFF;

  // One result of the tracker, field by field.
  typedef struct packed {
    outcome_e    outcome;
    logic [15:0] blank_ticks;
    logic [15:0] period;
    logic        load_valid;
    logic [14:0] load_value;
    logic [12:0] blank_compare;
    logic        starting;
    logic [7:0]  confirm_needed;
  } tracker_result_t;

  logic clk_i;
  logic rst_ni;

  bzct_cfg_if                   cfg_bus ();
  bzct_in_if  #(.TIMER_BITS(16)) in_bus ();
  bzct_out_if #(.TIMER_BITS(16)) out_bus ();

  bldc_zero_cross_commutation_tracker #(.TIMER_BITS(16)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // Register copies.
  logic [7:0]  reg_startup_conf;
  logic [15:0] reg_startup_period;
  logic [7:0]  reg_slow_conf;
  logic [15:0] reg_reject_blank;

  // Tracker state copies.
  logic        starting;
  logic [7:0]  remaining_conf;
  logic [7:0]  required_conf;
  logic [7:0]  run_conf;
  logic [15:0] comm_period;

  tracker_result_t tracker_results[$];

  int unsigned errors;
  int unsigned items_sent;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned hold_left;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #(CLK_PERIOD * RUN_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Nudge the run confirmation count according to the speed band of the interval.
  function automatic void adapt_run_conf(logic [15:0] cnt);
    if (cnt < FAST_TICKS) begin
      if (run_conf > FAST_MIN_CONF) run_conf--;
    end else if (cnt < MEDIUM_TICKS) begin
      if (run_conf > MEDIUM_MIN_CONF) run_conf--;
    end else if (cnt < SLOW_TICKS) begin
      if (run_conf > SLOW_MIN_CONF) run_conf--;
    end else if (run_conf < reg_slow_conf) begin
      run_conf++;
    end
  endfunction

  // Advance the tracker state by one request and return the result it gives.
  function automatic tracker_result_t track_request(logic req, logic level, logic [15:0] cnt);
    tracker_result_t res;
    logic [15:0]     p;
    int unsigned     late;
    res = '0;
    res.outcome = OUT_CONFIRMING;
    if (req == REQ_TIMEOUT) begin
      starting = 1'b1;
      res.outcome = OUT_TIMEOUT;
    end else if (!level) begin
      remaining_conf = required_conf;
      res.outcome = OUT_REJECTED;
      res.blank_ticks = reg_reject_blank;
    end else if (remaining_conf > 8'd1) begin
      remaining_conf--;
    end else begin
      p = comm_period;
      late = p + (p >> 1) + (p >> 2);
      res.outcome = OUT_ACCEPTED;
      if (cnt < ZC_MIN_TICKS) starting = 1'b1;
      if (cnt < (p >> 1)) begin
        if (starting) begin
          required_conf = reg_startup_conf;
          comm_period = reg_startup_period;
        end
      end else if (cnt > late) begin
        // Missed window: period and required count stay as they are.
      end else if (starting) begin
        starting = 1'b0;
      end else begin
        adapt_run_conf(cnt);
        required_conf = run_conf;
        comm_period = 16'((p >> 1) + (p >> 2) + (cnt >> 2));
        res.load_valid = 1'b1;
        res.load_value = comm_period[15:1];
      end
      remaining_conf = required_conf;
      res.blank_compare = comm_period[15:3];
    end
    res.period = comm_period;
    res.starting = starting;
    res.confirm_needed = required_conf;
    return res;
  endfunction

  // Mirror one register write; data is kept at the register's width.
  function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_STARTUP_CONF:   reg_startup_conf = data[7:0];
      CFG_STARTUP_PERIOD: reg_startup_period = data;
      CFG_SLOW_CONF:      reg_slow_conf = data[7:0];
      CFG_REJECT_BLANK:   reg_reject_blank = data;
      default: ;
    endcase
  endfunction

  // Interval for an accepting sample: mostly in window, the rest early, short, missed or fully random.
  function automatic logic [15:0] pick_interval();
    int unsigned p;
    int unsigned half;
    int unsigned late;
    int unsigned roll;
    int unsigned value;
    p = comm_period;
    half = p >> 1;
    late = p + (p >> 1) + (p >> 2);
    roll = $urandom_range(99);
    if (roll < 55) begin
      value = $urandom_range((late > 65535) ? 65535 : late, half);
    end else if (roll < 67) begin
      value = (half > 0) ? $urandom_range(half - 1, 0) : 0;
    end else if (roll < 75) begin
      value = $urandom_range(ZC_MIN_TICKS - 1, 0);
    end else if (roll < 87) begin
      value = (late < 65535) ? $urandom_range(65535, late + 1) : 65535;
    end else begin
      value = $urandom_range(65535, 0);
    end
    return 16'(value);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Send one request, idling first as the sender mode asks, and predict its result.
  task automatic send_request(logic req, logic level, logic [15:0] cnt);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk_i);
      in_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_bus.valid <= 1'b1;
    in_bus.req_type <= req;
    in_bus.comp_level <= level;
    in_bus.zc_count <= cnt;
    do @(posedge clk_i); while (!in_bus.ready);
    tracker_results.push_back(track_request(req, level, cnt));
    items_sent++;
  endtask

  // A full run of high samples; the last one carries the given interval.
  task automatic send_crossing(logic [15:0] cnt);
    int unsigned needed;
    needed = (remaining_conf > 8'd1) ? remaining_conf : 1;
    for (int unsigned i = 0; i < needed; i++) begin
      if (i + 1 == needed) send_request(REQ_SAMPLE, 1'b1, cnt);
      else send_request(REQ_SAMPLE, 1'b1, 16'($urandom));
    end
  endtask

  // One random unit of traffic: a timeout, a noise sample, or a crossing that may be broken.
  task automatic send_random_crossing();
    int unsigned roll;
    int unsigned needed;
    int unsigned break_at;
    roll = $urandom_range(99);
    if (roll < 5) begin
      send_request(REQ_TIMEOUT, 1'($urandom), 16'($urandom));
    end else if (roll < 15) begin
      send_request(REQ_SAMPLE, 1'($urandom), 16'($urandom));
    end else begin
      needed = (remaining_conf > 8'd1) ? remaining_conf : 1;
      break_at = (roll < 22) ? $urandom_range(needed - 1, 0) : needed;
      for (int unsigned i = 0; i < needed; i++) begin
        if (i == break_at) begin
          send_request(REQ_SAMPLE, 1'b0, 16'($urandom));
          return;
        end else if (i + 1 == needed) begin
          send_request(REQ_SAMPLE, 1'b1, pick_interval());
        end else begin
          send_request(REQ_SAMPLE, 1'b1, 16'($urandom));
        end
      end
    end
  endtask

  // Stop offering requests and wait until every predicted result has come out.
  task automatic wait_idle();
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    while (tracker_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    apply_register(idx, data);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Moderate settings for random traffic; the upper bytes of 8-bit registers are junk.
  task automatic set_random_config(logic [15:0] period);
    write_register(CFG_STARTUP_CONF, {8'($urandom), 8'($urandom_range(6, 1))});
    write_register(CFG_STARTUP_PERIOD, period);
    write_register(CFG_SLOW_CONF, {8'($urandom), 8'($urandom_range(24, 6))});
    write_register(CFG_REJECT_BLANK, 16'($urandom));
  endtask

  // Both request kinds, a rejected sample and early, missed and in-window crossings under the reset settings.
  task automatic test_request_kinds();
    send_request(REQ_TIMEOUT, 1'b1, 16'hFFFF);
    send_request(REQ_SAMPLE, 1'b0, 16'h0000);
    send_crossing(16'd0);       // very short interval, early while starting
    send_crossing(16'hFFFF);    // missed while starting
    send_crossing(16'd20000);   // in window while starting
    send_crossing(16'd5000);    // early while running
    send_crossing(16'd20000);   // in window while running
    send_request(REQ_SAMPLE, 1'b0, 16'hFFFF);
    send_request(REQ_TIMEOUT, 1'b0, 16'h0000);
    wait_idle();
  endtask

  // Register extremes, masking, unused indexes and the empty run.
  task automatic test_register_extremes();
    write_register(CFG_STARTUP_CONF, 16'hFF00);
    write_register(CFG_STARTUP_PERIOD, 16'hFFFF);
    write_register(CFG_SLOW_CONF, 16'h01FF);
    write_register(CFG_REJECT_BLANK, 16'hFFFF);
    write_register(CFG_SPARE_INDEX, 16'hFFFF);
    write_register(CFG_LAST_INDEX, 16'h5A5A);
    send_crossing(16'd0);                        // loads a run count of zero
    send_request(REQ_SAMPLE, 1'b1, 16'd0);       // empty run accepts at once
    send_request(REQ_SAMPLE, 1'b1, 16'hFFFF);    // wide missed-window compare
    send_request(REQ_SAMPLE, 1'b1, 16'hFFFF);    // running, slow band
    send_request(REQ_SAMPLE, 1'b0, 16'($urandom));
    wait_idle();
    write_register(CFG_STARTUP_CONF, 16'h00FF);
    write_register(CFG_REJECT_BLANK, 16'h0000);
    send_request(REQ_TIMEOUT, 1'b1, 16'($urandom));
    send_crossing(16'd0);
    send_request(REQ_SAMPLE, 1'b0, 16'd0);
    wait_idle();
    write_register(CFG_STARTUP_CONF, 16'h0003);
    send_crossing(16'd0);                        // longest run
    wait_idle();
  endtask

  // Receiver holds off long enough to fill the block, then the sender pauses to drain, then random stalls follow.
  task automatic test_output_backpressure();
    set_random_config(16'd8000);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_left = 150;
    repeat (40) send_random_crossing();
    wait_idle();
    receiver_stall_pct = 30;
    repeat (20) send_random_crossing();
    receiver_stall_pct = 0;
    wait_idle();
  endtask

  // Random crossing traffic over several settings and idling modes.
  task automatic test_random_traffic();
    logic [15:0] periods[5];
    int unsigned send_idle[5];
    int unsigned recv_stall[5];
    int unsigned target;
    periods = '{16'd7000, 16'd9000, 16'd12000, 16'd4000, 16'd30000};
    send_idle = '{0, 70, 0, 10, 0};
    recv_stall = '{0, 0, 70, 10, 0};
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      set_random_config(periods[ph]);
      sender_idle_pct = send_idle[ph];
      receiver_stall_pct = recv_stall[ph];
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) send_random_crossing();
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    wait_idle();
  endtask

  // A zero period cannot be left once loaded, so this runs last.
  task automatic test_zero_period();
    write_register(CFG_STARTUP_PERIOD, 16'h0000);
    write_register(CFG_STARTUP_CONF, 16'h0002);
    send_request(REQ_TIMEOUT, 1'b1, 16'($urandom));
    send_crossing(16'd0);
    send_crossing(16'd0);
    send_crossing(16'd5);
    send_crossing(16'd0);
    wait_idle();
  endtask

  // Receiver: random stalls, or a counted hold-off when one is asked for.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Compare each accepted result with the oldest prediction.
  initial begin
    tracker_result_t got;
    tracker_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) begin
        got.outcome = out_bus.outcome;
        got.blank_ticks = out_bus.blank_ticks;
        got.period = out_bus.period_out;
        got.load_valid = out_bus.comm_load_valid;
        got.load_value = out_bus.comm_load_value;
        got.blank_compare = out_bus.blank_compare;
        got.starting = out_bus.starting_out;
        got.confirm_needed = out_bus.confirm_needed;
        if (tracker_results.size() == 0) begin
          report_mismatch("result with nothing awaited, outcome", got.outcome, 0);
        end else begin
          want = tracker_results.pop_front();
          check_field("outcome", got.outcome, want.outcome);
          check_field("blank_ticks", got.blank_ticks, want.blank_ticks);
          check_field("period_out", got.period, want.period);
          check_field("comm_load_valid", got.load_valid, want.load_valid);
          check_field("comm_load_value", got.load_value, want.load_value);
          check_field("blank_compare", got.blank_compare, want.blank_compare);
          check_field("starting_out", got.starting, want.starting);
          check_field("confirm_needed", got.confirm_needed, want.confirm_needed);
        end
      end
    end
  end

  // Reset, then the tests in turn.
  initial begin
    rst_ni = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    in_bus.valid = 1'b0;
    in_bus.req_type = REQ_SAMPLE;
    in_bus.comp_level = 1'b0;
    in_bus.zc_count = '0;
    errors = 0;
    items_sent = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_left = 0;
    reg_startup_conf = RST_STARTUP_CONF;
    reg_startup_period = RST_STARTUP_PERIOD;
    reg_slow_conf = RST_SLOW_CONF;
    reg_reject_blank = RST_REJECT_BLANK;
    starting = 1'b1;
    remaining_conf = RST_STARTUP_CONF;
    required_conf = RST_STARTUP_CONF;
    run_conf = RST_SLOW_CONF;
    comm_period = RST_STARTUP_PERIOD;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_request_kinds();
    test_register_extremes();
    test_output_backpressure();
    test_random_traffic();
    test_zero_period();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
